// ===== rtl/prrs_pkg.sv =====
// Package for the priority round-robin scheduler: task record type and constants.
// No dependencies.
`default_nettype none
package prrs_pkg;
   localparam int TASK_SLOTS_DEF = 16;
   localparam logic [7:0] QUANTUM_RESET = 8'd4;
   localparam int TASK_W = 40;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] left;
   } task_type;

   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/prrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module prrs_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/priority_round_robin_scheduler_unit.sv =====
// Top level of the priority round-robin scheduler.
// Depends on prrs_pkg and prrs_ram (priority slot memory and FIFO memory).
//
// channel   ports                                   handshake
// request   req_func req_task_id req_task_priority  start / busy
//           req_burst_length
// response  rsp_accepted rsp_ran rsp_running_id     rsp_valid, one cycle
//           rsp_finished
// config    csr_time_quantum                        csr_we
//
// For an arrival, busy stays low and the response follows the accepting edge.
// A tick steps through S_SCAN, S_SCAN_LAST, S_FPOP, S_RUN and then S_PUSH once per FIFO
// push (a preemption and a quantum expiry push one each, so up to two): the best-slot
// search reads the priority memory one slot a cycle through its single read port, then
// dispatch and FIFO pop or push follow. The response is registered from S_RUN. Synchronous
// reset clears valid bits, FIFO pointers and the running task; memory contents stay undefined
// until written. The receiver cannot stall.
`default_nettype none
module priority_round_robin_scheduler_unit #(
   parameter int TASK_SLOTS = prrs_pkg::TASK_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0]  req_task_priority,
   input  wire logic [15:0] req_burst_length,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic             rsp_ran,
   output logic [15:0]      rsp_running_id,
   output logic             rsp_finished,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_time_quantum
);
   localparam int AW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);
   localparam logic [AW-1:0] LAST_A = AW'(TASK_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SCAN_LAST, S_FPOP, S_RUN, S_PUSH
   } state_type;

   state_type                  state_ff;
   logic [TASK_SLOTS-1:0]      valid_ff;
   logic [AW-1:0]              head_ff, tail_ff;
   logic [CW-1:0]              fcount_ff;
   prrs_pkg::task_type         cur_ff;
   logic                       run_ff, from_pri_ff, from_fifo_ff;
   logic [7:0]                 qleft_ff, quantum_ff;
   logic [AW-1:0]              scan_ff, rd_idx_ff, best_ff;
   logic                       found_ff;
   prrs_pkg::task_type         best_task_ff;
   prrs_pkg::task_type         push_task_ff;
   logic                       push2_ff;
   prrs_pkg::task_type         push2_task_ff;

   // memory ports
   logic                       p_we;
   logic [AW-1:0]              p_wa, p_ra;
   prrs_pkg::task_type         p_wd, p_rd;
   logic                       f_we;
   logic [AW-1:0]              f_wa;
   prrs_pkg::task_type         f_wd, f_rd;

   prrs_ram #(.WIDTH(prrs_pkg::TASK_W), .DEPTH(TASK_SLOTS)) u_pri (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   prrs_ram #(.WIDTH(prrs_pkg::TASK_W), .DEPTH(TASK_SLOTS)) u_fifo (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(head_ff), .rd_data(f_rd));

   // first free slot and valid count
   logic [AW-1:0] free_idx;
   logic          free_any;
   logic [CW-1:0] pcount;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      pcount = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = AW'(i);
            free_any = 1'b1;
         end
         pcount = pcount + CW'(valid_ff[i]);
      end
   end

   logic [CW+1:0] stored;
   assign stored = (CW+2)'(pcount) + (CW+2)'(fcount_ff) + (CW+2)'(run_ff);

   logic take;
   assign take = start && !busy;
   assign busy = (state_ff != S_IDLE);

   // search compare on data read last cycle
   logic better;
   assign better = valid_ff[rd_idx_ff] && (!found_ff || p_rd.prio < best_task_ff.prio ||
                   (p_rd.prio == best_task_ff.prio && p_rd.id < best_task_ff.id));

   always_comb begin
      p_we = 1'b0;
      p_wa = free_idx;
      p_wd = '{id: req_task_id, prio: req_task_priority, left: req_burst_length};
      p_ra = scan_ff;
      f_we = 1'b0;
      f_wa = tail_ff;
      f_wd = push_task_ff;
      if (take && req_func == prrs_pkg::FUNC_ARRIVAL && req_burst_length != 16'd0 &&
          free_any && stored < (CW+2)'(SLOTS_C)) begin
         p_we = 1'b1;
      end
      if (state_ff == S_PUSH && fcount_ff < SLOTS_C) begin
         f_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prrs_pkg::task_type t;
      logic               r, fp, ff, fin, exp, pre;
      logic [7:0]         q;
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fcount_ff    <= '0;
         cur_ff       <= '0;
         run_ff       <= 1'b0;
         from_pri_ff  <= 1'b0;
         from_fifo_ff <= 1'b0;
         qleft_ff     <= prrs_pkg::QUANTUM_RESET;
         quantum_ff   <= prrs_pkg::QUANTUM_RESET;
         rsp_valid    <= 1'b0;
         push2_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            quantum_ff <= csr_time_quantum;
         end
         rsp_valid <= (state_ff == S_RUN) || (take && req_func == prrs_pkg::FUNC_ARRIVAL);
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  if (req_func == prrs_pkg::FUNC_ARRIVAL) begin
                     if (p_we) begin
                        valid_ff[free_idx] <= 1'b1;
                     end
                     rsp_accepted   <= p_we;
                     rsp_ran        <= 1'b0;
                     rsp_running_id <= '0;
                     rsp_finished   <= 1'b0;
                  end else begin
                     scan_ff  <= '0;
                     found_ff <= 1'b0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // read address scan_ff issued this cycle; compare the prior one
               rd_idx_ff <= scan_ff;
               if (scan_ff != '0 && better) begin
                  found_ff <= 1'b1;
                  best_ff <= rd_idx_ff;
                  best_task_ff <= p_rd;
               end
               if (scan_ff == LAST_A) begin
                  state_ff <= S_SCAN_LAST;
               end else begin
                  scan_ff <= scan_ff + AW'(1);
               end
            end
            S_SCAN_LAST: begin
               if (better) begin
                  found_ff <= 1'b1;
                  best_ff <= rd_idx_ff;
                  best_task_ff <= p_rd;
               end
               state_ff <= S_FPOP;
            end
            S_FPOP: begin
               // FIFO head read is ready here (head register stable)
               state_ff <= S_RUN;
            end
            S_RUN: begin
               t = cur_ff; r = run_ff; fp = from_pri_ff; ff = from_fifo_ff; q = qleft_ff;
               pre = 1'b0;
               if (!r) begin
                  if (found_ff) begin
                     t = best_task_ff; valid_ff[best_ff] <= 1'b0;
                     r = 1'b1; fp = 1'b1; q = quantum_ff;
                  end else if (fcount_ff != '0) begin
                     t = f_rd; head_ff <= (head_ff == LAST_A) ? '0 : head_ff + AW'(1);
                     fcount_ff <= fcount_ff - CW'(1);
                     r = 1'b1; ff = 1'b1; q = quantum_ff;
                  end
               end else if (found_ff && (fp ? best_task_ff.prio < t.prio : ff)) begin
                  pre = 1'b1;
                  t = best_task_ff; valid_ff[best_ff] <= 1'b0;
                  fp = 1'b1; ff = 1'b0; q = quantum_ff;
               end
               fin = 1'b0;
               exp = 1'b0;
               if (r) begin
                  t.left = t.left - 16'd1;
                  q = q - 8'd1;
                  fin = (t.left == 16'd0);
                  exp = !fin && (q == 8'd0);
                  if (fin) begin
                     r = 1'b0; fp = 1'b0; ff = 1'b0; q = quantum_ff;
                  end else if (exp) begin
                     r = 1'b0; fp = 1'b0; ff = 1'b0;
                  end
               end
               // push the preempted task first, an expired one after it
               if (pre) begin
                  push_task_ff <= cur_ff;
                  push2_ff <= exp;
               end else begin
                  push_task_ff <= t;
                  push2_ff <= 1'b0;
               end
               push2_task_ff <= t;
               state_ff <= (pre || exp) ? S_PUSH : S_IDLE;
               cur_ff <= t; run_ff <= r; from_pri_ff <= fp; from_fifo_ff <= ff;
               qleft_ff <= q;
               rsp_accepted   <= 1'b0;
               rsp_ran        <= run_ff || found_ff || fcount_ff != '0;
               rsp_running_id <= (run_ff || found_ff || fcount_ff != '0) ? t.id : 16'd0;
               rsp_finished   <= fin;
            end
            S_PUSH: begin
               if (fcount_ff < SLOTS_C) begin
                  tail_ff <= (tail_ff == LAST_A) ? '0 : tail_ff + AW'(1);
                  fcount_ff <= fcount_ff + CW'(1);
               end
               if (push2_ff) begin
                  push2_ff <= 1'b0;
                  push_task_ff <= push2_task_ff;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/prrs_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
// Depends on prrs_pkg and priority_round_robin_scheduler_unit ports only.
`default_nettype none
module prrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_func,
   input wire logic        rsp_valid,
   input wire logic        rsp_accepted,
   input wire logic        rsp_ran,
   input wire logic [15:0] rsp_running_id,
   input wire logic        rsp_finished
);
   a_arrival_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == prrs_pkg::FUNC_ARRIVAL) |=> rsp_valid)
      else $error("arrival transaction without response");
   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ran) |-> (rsp_running_id == 16'd0 && !rsp_finished))
      else $error("idle response carries id or finish");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_ran))
      else $error("accepted and ran together");
   a_no_resp_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy) && !$past(start)) |-> !rsp_valid)
      else $error("response without transaction");
endmodule

bind priority_round_robin_scheduler_unit prrs_checker u_prrs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_func(req_func),
   .rsp_valid(rsp_valid), .rsp_accepted(rsp_accepted), .rsp_ran(rsp_ran),
   .rsp_running_id(rsp_running_id), .rsp_finished(rsp_finished));
`default_nettype wire

// ===== bench/priority_round_robin_scheduler_unit_tb.sv =====
// Self-checking bench for the priority round-robin scheduler unit.
// Depends on prrs_pkg and the scheduler RTL; holds its own scheduler predictor.
`timescale 1ns / 1ps
module priority_round_robin_scheduler_unit_tb;
   localparam int SLOTS = 16;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic        accepted;
      logic        ran;
      logic [15:0] running_id;
      logic        finished;
   } sched_out_type;

   typedef struct {
      logic          func;
      logic [15:0]   id;
      logic [7:0]    prio;
      logic [15:0]   burst;
      logic          has_exp;
      sched_out_type exp_out;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_func = 0;
   logic [15:0] req_task_id = 0;
   logic [7:0]  req_task_priority = 0;
   logic [15:0] req_burst_length = 0;
   logic        rsp_valid, rsp_accepted, rsp_ran, rsp_finished;
   logic [15:0] rsp_running_id;
   logic        csr_we = 0;
   logic [7:0]  csr_time_quantum = 0;

   priority_round_robin_scheduler_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_task_id(req_task_id),
      .req_task_priority(req_task_priority), .req_burst_length(req_burst_length),
      .rsp_valid(rsp_valid), .rsp_accepted(rsp_accepted), .rsp_ran(rsp_ran),
      .rsp_running_id(rsp_running_id), .rsp_finished(rsp_finished),
      .csr_we(csr_we), .csr_time_quantum(csr_time_quantum)
   );

   always #2 clock = ~clock;

   // predictor state
   prrs_pkg::task_type pset [SLOTS];
   logic               pvalid [SLOTS];
   prrs_pkg::task_type rrq [$];
   prrs_pkg::task_type cur;
   logic               running;
   logic               from_prio, from_rrq;
   logic [7:0]         qleft, quantum;

   sched_out_type expected_q [$];
   int            errors = 0;
   int            cycles = 0;
   int            idle_pct = 0;

   function automatic int best_slot();
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++)
         if (pvalid[i] && (b < 0 || pset[i].prio < pset[b].prio ||
             (pset[i].prio == pset[b].prio && pset[i].id < pset[b].id)))
            b = i;
      return b;
   endfunction

   function automatic sched_out_type schedule(logic f, logic [15:0] id,
                                              logic [7:0] pr, logic [15:0] bl);
      sched_out_type o;
      int b, n;
      o = '0;
      if (f == prrs_pkg::FUNC_ARRIVAL) begin
         n = rrq.size() + (running ? 1 : 0);
         for (int i = 0; i < SLOTS; i++) if (pvalid[i]) n++;
         if (bl != 0 && n < SLOTS) begin
            for (int i = 0; i < SLOTS; i++)
               if (!pvalid[i]) begin
                  pset[i] = '{id: id, prio: pr, left: bl};
                  pvalid[i] = 1;
                  o.accepted = 1;
                  break;
               end
         end
      end else begin
         b = best_slot();
         if (!running) begin
            if (b >= 0) begin
               cur = pset[b]; pvalid[b] = 0; running = 1; from_prio = 1;
               qleft = quantum;
            end else if (rrq.size() > 0) begin
               cur = rrq.pop_front(); running = 1; from_rrq = 1; qleft = quantum;
            end
         end else if (from_prio && b >= 0) begin
            if (pset[b].prio < cur.prio) begin
               if (rrq.size() < SLOTS) rrq = {rrq, cur};
               cur = pset[b]; pvalid[b] = 0; qleft = quantum;
            end
         end else if (from_rrq && b >= 0) begin
            if (rrq.size() < SLOTS) rrq = {rrq, cur};
            cur = pset[b]; pvalid[b] = 0; from_rrq = 0; from_prio = 1;
            qleft = quantum;
         end
         if (running) begin
            cur.left = cur.left - 16'd1;
            qleft = qleft - 8'd1;
            o.ran = 1;
            o.running_id = cur.id;
            if (cur.left == 0) begin
               o.finished = 1; running = 0; qleft = quantum;
               from_prio = 0; from_rrq = 0;
            end else if (qleft == 0) begin
               if (rrq.size() < SLOTS) rrq = {rrq, cur};
               running = 0; from_prio = 0; from_rrq = 0;
            end
         end
      end
      return o;
   endfunction

   task automatic send(logic f, logic [15:0] id, logic [7:0] pr, logic [15:0] bl,
                       logic has_exp = 0, sched_out_type fixed = '0);
      sched_out_type p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_func <= f;
      req_task_id <= id;
      req_task_priority <= pr;
      req_burst_length <= bl;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = schedule(f, id, pr, bl);
      if (has_exp && p !== fixed) begin
         $error("directed row: predictor %h, table %h", p, fixed);
         errors++;
      end
      if (has_exp) p = fixed;
      expected_q = {expected_q, p};
   endtask

   task automatic drain_and_set(logic [7:0] q);
      start <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1;
      csr_time_quantum <= q;
      @(posedge clock);
      csr_we <= 0;
      quantum = q;
   endtask

   // results: check against the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("result with no transaction pending");
            errors++;
         end else begin
            sched_out_type e;
            e = expected_q.pop_front();
            if (rsp_accepted !== e.accepted) begin
               $error("accepted: expected %0d actual %0d", e.accepted, rsp_accepted);
               errors++;
            end
            if (rsp_ran !== e.ran) begin
               $error("ran: expected %0d actual %0d", e.ran, rsp_ran);
               errors++;
            end
            if (rsp_running_id !== e.running_id) begin
               $error("running_id: expected %0d actual %0d",
                      e.running_id, rsp_running_id);
               errors++;
            end
            if (rsp_finished !== e.finished) begin
               $error("finished: expected %0d actual %0d", e.finished, rsp_finished);
               errors++;
            end
         end
      end
      if (cycles == LIMIT) begin
         $display("priority_round_robin_scheduler_unit_tb NOT OK");
         $finish;
      end
   end

   dir_row_type dir_rows [17] = '{
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    1, '{0, 0, 16'd0, 0}},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd5,    8'd9,  16'd0,    1, '{0, 0, 16'd0, 0}},
      '{prrs_pkg::FUNC_ARRIVAL, 16'hFFFF, 8'hFF, 16'hFFFF, 1, '{1, 0, 16'd0, 0}},
      '{prrs_pkg::FUNC_TICK,    16'hFFFF, 8'hFF, 16'hFFFF, 1, '{0, 1, 16'hFFFF, 0}},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd0,    8'd0,  16'd1,    1, '{1, 0, 16'd0, 0}},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    1, '{0, 1, 16'd0, 1}},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd7,    8'd3,  16'd2,    0, '0},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd7,    8'd3,  16'd2,    0, '0},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd2,    8'd3,  16'd3,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_ARRIVAL, 16'd9,    8'd1,  16'd5,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0},
      '{prrs_pkg::FUNC_TICK,    16'd0,    8'd0,  16'd0,    0, '0}
   };

   initial begin
      int n;
      logic [7:0] qset [5] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2};
      for (int i = 0; i < SLOTS; i++) pvalid[i] = 0;
      running = 0; from_prio = 0; from_rrq = 0;
      qleft = prrs_pkg::QUANTUM_RESET; quantum = prrs_pkg::QUANTUM_RESET;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i])
         send(dir_rows[i].func, dir_rows[i].id, dir_rows[i].prio,
              dir_rows[i].burst, dir_rows[i].has_exp, dir_rows[i].exp_out);
      // fill past capacity to hit the rejection path
      for (int i = 0; i < SLOTS + 2; i++)
         send(prrs_pkg::FUNC_ARRIVAL, 16'(100 + i), 8'($urandom_range(255)), 16'd3);
      for (int i = 0; i < 70; i++) send(prrs_pkg::FUNC_TICK, 16'd0, 8'd0, 16'd0);

      for (int ph = 0; ph < 5; ph++) begin
         drain_and_set(qset[ph]);
         idle_pct = (ph == 1 || ph == 3) ? 76 : (ph == 2 ? 9 : 0);
         n = (ph == 2) ? 100 : 200;
         for (int i = 0; i < n; i++) begin
            logic [15:0] id, bl;
            logic [7:0] pr;
            id = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(15));
            pr = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
            case ($urandom_range(9))
               0: bl = 16'd0;
               1: bl = 16'($urandom);
               default: bl = 16'($urandom_range(1, 8));
            endcase
            send($urandom_range(99) < 55 ? prrs_pkg::FUNC_TICK : prrs_pkg::FUNC_ARRIVAL,
                 id, pr, bl);
         end
      end

      start <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("priority_round_robin_scheduler_unit_tb OK");
      else
         $display("priority_round_robin_scheduler_unit_tb NOT OK");
      $finish;
   end
endmodule
